@@ rtl/r2a_pkg.sv @@
// ----------------------------------------------------------------------------
// r2a_pkg
// Types, constants and lookup tables shared by the RGBA-cell-to-glyph block.
// ----------------------------------------------------------------------------
`default_nettype none

package r2a_pkg;

  localparam int CELL_PIXELS = 8;
  localparam int GLYPH_COUNT = 92;
  localparam int TABLE_SIZE  = 92;
  localparam int EFF_COUNT   = (GLYPH_COUNT < 2) ? 2 :
                               ((GLYPH_COUNT > TABLE_SIZE) ? TABLE_SIZE : GLYPH_COUNT);
  // thresholds counted and glyphs used
  localparam int RAMP_LEN    = EFF_COUNT - 1;
  localparam int RAMP_CHARS  = 91;

  localparam int CH_W   = 8;
  localparam int SUM_W  = 11;
  localparam int CNT_W  = 4;
  localparam int COEF_W = 16;
  localparam int ACC_W  = 24;
  localparam int LUMA_W = 16;
  localparam int CODE_W = 7;
  localparam int IDX_W  = 7;

  localparam logic [COEF_W-1:0] COEF_R = 16'd13933;
  localparam logic [COEF_W-1:0] COEF_G = 16'd46871;
  localparam logic [COEF_W-1:0] COEF_B = 16'd4732;

  localparam logic [CODE_W-1:0] CHAR_SPACE = 7'd32;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRUECOLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE   = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            last_of_cell;
    logic            last_of_row;
  } r2a_pix_t;

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic              color_change;
    logic [CH_W-1:0]   avg_red;
    logic [CH_W-1:0]   avg_green;
    logic [CH_W-1:0]   avg_blue;
    logic              line_end;
  } r2a_res_t;

  // one finished cell, handed from accumulator to back end
  typedef struct packed {
    logic [SUM_W-1:0] red_sum;
    logic [SUM_W-1:0] green_sum;
    logic [SUM_W-1:0] blue_sum;
    logic [CNT_W-1:0] opaque_count;
    logic             row_end;
  } r2a_cmd_t;

  typedef struct packed {
    logic truecolor_enable;
    logic inverse_ramp;
  } r2a_cfg_t;

  localparam logic [LUMA_W-1:0] THRESH [TABLE_SIZE] = '{
    16'd0,     16'd4266,  16'd5433,  16'd5557,  16'd8041,  16'd9195,  16'd10217,
    16'd12124, 16'd14307, 16'd15840, 16'd16849, 16'd18691, 16'd19019, 16'd19130,
    16'd20310, 16'd20919, 16'd21181, 16'd21588, 16'd22177, 16'd23652, 16'd23717,
    16'd24032, 16'd24491, 16'd24556, 16'd25153, 16'd25697, 16'd25952, 16'd26110,
    16'd26169, 16'd26706, 16'd26811, 16'd26876, 16'd27525, 16'd27722, 16'd27833,
    16'd28010, 16'd28135, 16'd28364, 16'd28718, 16'd28738, 16'd28967, 16'd29314,
    16'd29340, 16'd29511, 16'd29898, 16'd30015, 16'd30212, 16'd30396, 16'd30586,
    16'd30710, 16'd30756, 16'd30822, 16'd31674, 16'd31988, 16'd32401, 16'd32461,
    16'd32716, 16'd36104, 16'd36484, 16'd36497, 16'd36641, 16'd36713, 16'd36713,
    16'd37028, 16'd37854, 16'd37860, 16'd38129, 16'd38470, 16'd39138, 16'd39315,
    16'd39603, 16'd39643, 16'd39931, 16'd39970, 16'd42369, 16'd42998, 16'd43221,
    16'd43457, 16'd44001, 16'd44296, 16'd44623, 16'd44669, 16'd45384, 16'd46131,
    16'd46439, 16'd47415, 16'd47854, 16'd48051, 16'd51131, 16'd53962, 16'd59225,
    16'd65529
  };

  // dark-to-bright ramp; first character is a backtick (octal 140)
  localparam logic [8*RAMP_CHARS-1:0] RAMP_STR =
    "\140.-':_,^=;><+!rc*/z?sLTv)J7(|Fi{C}fI31tlu[neoZ5Yxjya]2ESwqkP6h9d4VpOGbUAKXHm8RD#$Bg0MNWQ%&@";

  function automatic logic [CODE_W-1:0] glyph_code(input logic [IDX_W-1:0] idx);
    logic [CODE_W-1:0] c;
    c = CHAR_SPACE;
    if (int'(idx) < RAMP_CHARS) begin
      c = RAMP_STR[8*(RAMP_CHARS-1-int'(idx)) +: CODE_W];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/r2a_fifo.sv @@
// ----------------------------------------------------------------------------
// r2a_fifo
// Small register-based queue; one push (while not full) and one pop (while not empty) per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module r2a_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ rtl/r2a_front.sv @@
// ----------------------------------------------------------------------------
// r2a_front
// Pixel accumulator: sums opaque pixels of a cell, emits one command per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module r2a_front import r2a_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     pix_valid,
  input  wire r2a_pix_t pix,
  output logic          cmd_push,
  output r2a_cmd_t      cmd
);

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CELL_PIXELS);

  logic [SUM_W-1:0] red_sum_r, red_sum_nxt;
  logic [SUM_W-1:0] green_sum_r, green_sum_nxt;
  logic [SUM_W-1:0] blue_sum_r, blue_sum_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             take;

  // pixels past a full cell are dropped
  assign take = (pix.alpha != '0) && (count_r < CNT_LIMIT);

  always_comb begin
    red_sum_nxt   = red_sum_r;
    green_sum_nxt = green_sum_r;
    blue_sum_nxt  = blue_sum_r;
    count_nxt     = count_r;
    if (take) begin
      red_sum_nxt   = red_sum_r + SUM_W'(pix.red);
      green_sum_nxt = green_sum_r + SUM_W'(pix.green);
      blue_sum_nxt  = blue_sum_r + SUM_W'(pix.blue);
      count_nxt     = count_r + 1'b1;
    end
  end

  assign cmd_push         = pix_valid && pix.last_of_cell;
  assign cmd.red_sum      = red_sum_nxt;
  assign cmd.green_sum    = green_sum_nxt;
  assign cmd.blue_sum     = blue_sum_nxt;
  assign cmd.opaque_count = count_nxt;
  assign cmd.row_end      = pix.last_of_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_sum_r   <= '0;
      green_sum_r <= '0;
      blue_sum_r  <= '0;
      count_r     <= '0;
    end else if (pix_valid) begin
      if (pix.last_of_cell) begin
        red_sum_r   <= '0;
        green_sum_r <= '0;
        blue_sum_r  <= '0;
        count_r     <= '0;
      end else begin
        red_sum_r   <= red_sum_nxt;
        green_sum_r <= green_sum_nxt;
        blue_sum_r  <= blue_sum_nxt;
        count_r     <= count_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/r2a_back.sv @@
// ----------------------------------------------------------------------------
// r2a_back
// Cell processor: serial divide, luma MAC, threshold search, glyph and color.
// ----------------------------------------------------------------------------
`default_nettype none

module r2a_back import r2a_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire r2a_cfg_t cfg,
  input  wire r2a_cmd_t cmd,
  input  wire logic     cmd_empty,
  output logic          cmd_pop,
  input  wire logic     res_full,
  output logic          res_push,
  output r2a_res_t      res
);

  localparam int DIV_STEPS  = SUM_W;
  localparam int DSTEP_W    = $clog2(DIV_STEPS);
  localparam int SRCH_STEPS = $clog2(RAMP_LEN + 1);
  localparam int SSTEP_W    = (SRCH_STEPS > 1) ? $clog2(SRCH_STEPS) : 1;
  localparam int POS_W      = IDX_W;
  localparam logic [DSTEP_W-1:0] DIV_LAST  = DSTEP_W'(DIV_STEPS - 1);
  localparam logic [SSTEP_W-1:0] SRCH_LAST = SSTEP_W'(SRCH_STEPS - 1);
  localparam logic [POS_W:0]     POS_MAX   = (POS_W+1)'(RAMP_LEN);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MAC  = 5'b00100,
    ST_SRCH = 5'b01000,
    ST_OUT  = 5'b10000
  } r2a_state_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } r2a_chan_t;

  // one restoring-division bit: returns {dividend/quotient, remainder}
  function automatic logic [SUM_W+CNT_W-1:0] div_step(
    input logic [SUM_W-1:0] d,
    input logic [CNT_W-1:0] rem,
    input logic [CNT_W-1:0] dvs
  );
    logic [CNT_W:0]   trial;
    logic [CNT_W-1:0] rem_n;
    logic             qbit;
    trial = {rem, d[SUM_W-1]};
    qbit  = (trial >= {1'b0, dvs});
    rem_n = qbit ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
    return {d[SUM_W-2:0], qbit, rem_n};
  endfunction

  r2a_state_t        state_r, state_nxt;
  logic [SUM_W-1:0]  qr_r, qg_r, qb_r;
  logic [CNT_W-1:0]  remr_r, remg_r, remb_r;
  logic [CNT_W-1:0]  dvs_r;
  logic              nonempty_r;
  logic              row_end_r;
  logic [DSTEP_W-1:0] dstep_r;
  r2a_chan_t         chan_r;
  logic [ACC_W-1:0]  acc_r;
  logic [SSTEP_W-1:0] sstep_r;
  logic [POS_W-1:0]  pos_r;
  logic [CH_W-1:0]   prev_red_r, prev_green_r, prev_blue_r;
  logic              color_valid_r;

  logic [SUM_W+CNT_W-1:0] sr, sg, sb;
  logic [CH_W-1:0]   avg_red, avg_green, avg_blue;
  logic [COEF_W-1:0] coef;
  logic [CH_W-1:0]   chan_val;
  logic [ACC_W-1:0]  product;
  logic [LUMA_W-1:0] luma;
  logic [POS_W:0]    stride, cand, cand_m1;
  logic              cand_ok;
  logic [POS_W-1:0]  pos_eff;
  logic [IDX_W-1:0]  glyph_idx;
  logic              change;
  logic              out_fire;

  assign sr = div_step(qr_r, remr_r, dvs_r);
  assign sg = div_step(qg_r, remg_r, dvs_r);
  assign sb = div_step(qb_r, remb_r, dvs_r);

  assign avg_red   = qr_r[CH_W-1:0];
  assign avg_green = qg_r[CH_W-1:0];
  assign avg_blue  = qb_r[CH_W-1:0];

  always_comb begin
    case (chan_r)
      CH_RED: begin
        coef     = COEF_R;
        chan_val = avg_red;
      end
      CH_GREEN: begin
        coef     = COEF_G;
        chan_val = avg_green;
      end
      default: begin
        coef     = COEF_B;
        chan_val = avg_blue;
      end
    endcase
  end

  assign product = ACC_W'(coef) * ACC_W'(chan_val);
  assign luma    = acc_r[ACC_W-1 -: LUMA_W];

  // binary search for the count of thresholds at or below luma
  assign stride  = (POS_W+1)'(1) << (SRCH_LAST - sstep_r);
  assign cand    = {1'b0, pos_r} + stride;
  assign cand_m1 = cand - 1'b1;
  always_comb begin
    cand_ok = 1'b0;
    if (cand <= POS_MAX) begin
      cand_ok = (luma >= THRESH[cand_m1[IDX_W-1:0]]);
    end
  end

  assign pos_eff   = (pos_r == '0) ? POS_W'(1) : pos_r;
  assign glyph_idx = cfg.inverse_ramp ? IDX_W'(RAMP_LEN) - pos_eff : pos_eff - 1'b1;

  assign change = nonempty_r && cfg.truecolor_enable &&
                  (!color_valid_r || (avg_red != prev_red_r) ||
                   (avg_green != prev_green_r) || (avg_blue != prev_blue_r));

  assign res.char_code    = nonempty_r ? glyph_code(glyph_idx) : CHAR_SPACE;
  assign res.color_change = change;
  assign res.avg_red      = avg_red;
  assign res.avg_green    = avg_green;
  assign res.avg_blue     = avg_blue;
  assign res.line_end     = row_end_r;

  assign cmd_pop  = (state_r == ST_IDLE) && !cmd_empty;
  assign out_fire = (state_r == ST_OUT) && !res_full;
  assign res_push = out_fire;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          state_nxt = (cmd.opaque_count == '0) ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (dstep_r == DIV_LAST) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (chan_r == CH_BLUE) begin
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (sstep_r == SRCH_LAST) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!res_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        dvs_r      <= cmd.opaque_count;
        nonempty_r <= (cmd.opaque_count != '0);
        row_end_r  <= cmd.row_end;
        remr_r     <= '0;
        remg_r     <= '0;
        remb_r     <= '0;
        dstep_r    <= '0;
        if (cmd.opaque_count == '0) begin
          qr_r <= '0;
          qg_r <= '0;
          qb_r <= '0;
        end else begin
          qr_r <= cmd.red_sum;
          qg_r <= cmd.green_sum;
          qb_r <= cmd.blue_sum;
        end
      end
      ST_DIV: begin
        {qr_r, remr_r} <= sr;
        {qg_r, remg_r} <= sg;
        {qb_r, remb_r} <= sb;
        dstep_r        <= dstep_r + 1'b1;
        chan_r         <= CH_RED;
        acc_r          <= '0;
      end
      ST_MAC: begin
        acc_r   <= acc_r + product;
        chan_r  <= (chan_r == CH_RED) ? CH_GREEN : CH_BLUE;
        sstep_r <= '0;
        pos_r   <= '0;
      end
      ST_SRCH: begin
        sstep_r <= sstep_r + 1'b1;
        if (cand_ok) begin
          pos_r <= cand[POS_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // color tracking across a row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_red_r    <= '0;
      prev_green_r  <= '0;
      prev_blue_r   <= '0;
      color_valid_r <= 1'b0;
    end else if (out_fire) begin
      if (row_end_r) begin
        prev_red_r    <= '0;
        prev_green_r  <= '0;
        prev_blue_r   <= '0;
        color_valid_r <= 1'b0;
      end else if (change) begin
        prev_red_r    <= avg_red;
        prev_green_r  <= avg_green;
        prev_blue_r   <= avg_blue;
        color_valid_r <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/rgba_cell_to_ascii_glyph_top.sv @@
// ----------------------------------------------------------------------------
// rgba_cell_to_ascii_glyph_top
// Turns cells of RGBA pixels into ASCII glyphs with average color.
// Pixels are accepted one per cycle while the cell queue has room.
// The back end takes one cell at a time through a serial divide, a luma MAC
// over the three channels, a threshold search and output, which waits while
// the result queue is full; an empty cell goes straight to output. No new cell
// is dequeued until the last one is out, so the divider and search set the rate.
// Synchronous active-low reset clears sums, color state, queues and config.
// ----------------------------------------------------------------------------
`default_nettype none

module rgba_cell_to_ascii_glyph_top import r2a_pkg::*; #(
  parameter int CMD_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  input  wire r2a_pix_t             in_data,
  output logic                      in_full,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output r2a_res_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic                 cfg_wdata
);

  r2a_cfg_t cfg_r;
  r2a_cmd_t front_cmd, back_cmd;
  r2a_res_t back_res;
  logic     pix_valid;
  logic     cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic     res_push, res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRUECOLOR: cfg_r.truecolor_enable <= cfg_wdata;
        CFG_INVERSE:   cfg_r.inverse_ramp     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_full   = cmd_full;
  assign pix_valid = in_push && !cmd_full;

  r2a_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix       (in_data),
    .cmd_push  (cmd_push),
    .cmd       (front_cmd)
  );

  r2a_fifo #(
    .WIDTH ($bits(r2a_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (front_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty)
  );

  r2a_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  r2a_fifo #(
    .WIDTH ($bits(r2a_res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

`default_nettype wire

@@ rtl/r2a_checker.sv @@
// ----------------------------------------------------------------------------
// r2a_checker
// Port-level assertions for the glyph block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module r2a_checker import r2a_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_full,
  input wire logic     out_empty,
  input wire logic     out_pop,
  input wire r2a_res_t out_data
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // every glyph is printable ASCII
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.char_code >= 7'd32 && out_data.char_code <= 7'd126))
    else $error("char_code out of printable range");

  // a space only comes from an empty cell: black and no color change
  a_space_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.char_code == CHAR_SPACE) |->
      (!out_data.color_change && out_data.avg_red == '0 &&
       out_data.avg_green == '0 && out_data.avg_blue == '0))
    else $error("space glyph with nonzero color fields");

  // a result not taken stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("pending result changed or vanished");

endmodule

bind rgba_cell_to_ascii_glyph_top r2a_checker u_r2a_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

`default_nettype wire
